// File: hdl/knxf16_pkg.sv
package knxf16_pkg;

  localparam int unsigned RawW    = 32;
  localparam int unsigned DivW    = 38;  // |value| * 100 < 2**38
  localparam int unsigned MantW   = 39;  // signed quotient
  localparam int unsigned RemW    = 8;
  localparam int unsigned ExpW    = 5;
  localparam int unsigned CntW    = 6;
  localparam int unsigned DivSteps = DivW;

  localparam logic [1:0]  FmtU16 = 2'd0;
  localparam logic [1:0]  FmtS16 = 2'd1;

  localparam logic [7:0]  Hundred    = 8'd100;
  localparam logic [15:0] InvalidWord = 16'h7FFF;
  localparam logic [ExpW-1:0] ExpLimit = 5'd15;
  localparam logic signed [12:0] MantMax = 13'sd2047;
  localparam logic signed [12:0] MantHalf = 13'sd1024;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StSign,
    StNorm
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic sign;
    logic norm_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic div_done;
    logic in_range;
  } dp_status_t;

endpackage

// File: hdl/knxf16_ctrl.sv
module knxf16_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  knxf16_pkg::dp_status_t status_i,
  output knxf16_pkg::dp_cmd_t    cmd_o,
  output logic                   busy_o
);
  import knxf16_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StMul;
      end
      StMul: begin
        state_d = status_i.bypass ? StSign : StDiv;
      end
      StDiv: begin
        if (status_i.div_done) state_d = StSign;
      end
      StSign: begin
        state_d = StNorm;
      end
      StNorm: begin
        if (status_i.in_range) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      StMul:  cmd_o.mul = 1'b1;
      StDiv:  cmd_o.div_step = 1'b1;
      StSign: cmd_o.sign = 1'b1;
      StNorm: begin
        cmd_o.norm_step = !status_i.in_range;
        cmd_o.finish    = status_i.in_range;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

// File: hdl/knxf16_dp.sv
module knxf16_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  knxf16_pkg::dp_cmd_t    cmd_i,
  input  logic signed [31:0]     raw_value_i,
  input  logic [1:0]             value_format_i,
  input  logic [7:0]             scale_divisor_i,
  output knxf16_pkg::dp_status_t status_o,
  output logic [15:0]            f16_word_o,
  output logic                   overflow_o,
  output logic                   valid_o
);
  import knxf16_pkg::*;

  logic [RawW-1:0]          mag_q;
  logic                     neg_in_q;
  logic [7:0]               div_q;
  logic                     bypass_q;
  logic [DivW-1:0]          quo_q;
  logic [RemW-1:0]          rem_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [MantW-1:0]  m_q;
  logic                     rnd_q;
  logic [ExpW-1:0]          ex_q;
  logic [15:0]              word_q;
  logic                     ovf_q;
  logic                     valid_q;

  logic signed [RawW-1:0]   load_val;
  logic                     load_neg;
  logic [RemW:0]            rem_sh;
  logic                     ge;
  logic [RemW:0]            rem_sub;
  logic [MantW-1:0]         quo_ext;
  logic signed [12:0]       mant_r;
  logic signed [12:0]       mant_f;
  logic [ExpW-1:0]          ex_f;
  logic                     neg_out;

  always_comb begin
    case (value_format_i)
      FmtU16:  load_val = {16'h0000, raw_value_i[15:0]};
      FmtS16:  load_val = {{16{raw_value_i[15]}}, raw_value_i[15:0]};
      default: load_val = raw_value_i;
    endcase
    load_neg = (value_format_i != FmtU16) && load_val[RawW-1];
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  assign quo_ext = {1'b0, quo_q};

  // round-back of the last bit shifted out, plus one renormalization on carry
  assign mant_r  = $signed(m_q[12:0]) + $signed({12'd0, rnd_q});
  assign neg_out = m_q[MantW-1];
  always_comb begin
    mant_f = mant_r;
    ex_f   = ex_q;
    if (mant_r > MantMax) begin
      mant_f = MantHalf;
      ex_f   = ex_q + 1'b1;
    end
  end

  assign status_o.bypass   = bypass_q;
  assign status_o.div_done = cnt_q == CntW'(DivSteps - 1);
  assign status_o.in_range = (m_q >= -MantW'(2048)) && (m_q <= MantW'(2047));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q    <= load_neg ? RawW'(-load_val) : RawW'(load_val);
      neg_in_q <= load_neg;
      div_q    <= (scale_divisor_i == 8'd0) ? 8'd1 : scale_divisor_i;
      bypass_q <= scale_divisor_i == Hundred;
    end
    if (cmd_i.mul) begin
      quo_q <= bypass_q ? {{(DivW-RawW){1'b0}}, mag_q}
                        : DivW'({{(DivW-RawW){1'b0}}, mag_q} * DivW'(Hundred));
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.sign) begin
      m_q   <= neg_in_q ? -$signed(quo_ext) : $signed(quo_ext);
      rnd_q <= 1'b0;
      ex_q  <= '0;
    end
    if (cmd_i.norm_step) begin
      rnd_q <= m_q[0];
      m_q   <= m_q >>> 1;
      ex_q  <= ex_q + 1'b1;
    end
    if (cmd_i.finish) begin
      if (ex_f > ExpLimit) begin
        word_q <= InvalidWord;
        ovf_q  <= 1'b1;
      end else begin
        word_q <= {neg_out, ex_f[3:0], mant_f[10:0]};
        ovf_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  assign f16_word_o = word_q;
  assign overflow_o = ovf_q;
  assign valid_o    = valid_q;

endmodule

// File: hdl/scaled_int_to_knx_f16_core.sv
// Scaled integer to KNX 2-byte float encoder.
//
// Command channel: a word is taken at a rising edge with start_i high and
// busy_o low. busy_o stays high until the result has been computed.
// Result channel: valid_o is high for exactly one cycle while f16_word_o and
// overflow_o hold the result; the receiver cannot stall, so it must take the
// word in that cycle. The result registers keep their value afterwards.
//
// From the accepting edge the word passes through the multiply state, a
// restoring divider that produces one quotient bit per cycle, the sign state
// and the normalize state, which shifts once for each step of the exponent k
// (the exponent before round-carry, at most 27) and then finishes; when the
// divisor is 100 the divider is skipped. busy_o falls in the cycle that
// valid_o rises, so the next word may be accepted on that same cycle.
// One word is in flight at a time.
//
// Reset returns the controller to idle and clears valid_o; no item in flight
// survives it.
module scaled_int_to_knx_f16_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] raw_value_i,
  input  logic [1:0]         value_format_i,
  input  logic [7:0]         scale_divisor_i,
  output logic               valid_o,
  output logic [15:0]        f16_word_o,
  output logic               overflow_o
);
  import knxf16_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  knxf16_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  knxf16_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .raw_value_i     (raw_value_i),
    .value_format_i  (value_format_i),
    .scale_divisor_i (scale_divisor_i),
    .status_o        (status),
    .f16_word_o      (f16_word_o),
    .overflow_o      (overflow_o),
    .valid_o         (valid_o)
  );

endmodule
